[rtl/reh_pkg.sv]
// shared constants, types and float helpers for the rotary embedding head router
// no dependencies; used by every rtl file of the block except reh_checker
package reh_pkg;

  localparam int HEAD_DIM    = 256;
  localparam int QUERY_HEADS = 8;
  localparam int PIPE_DEPTH  = 8;

  localparam logic [15:0] BF16_QNAN = 16'h7FC0;
  localparam logic [31:0] FP32_QNAN = 32'h7FC00000;

  typedef enum logic [1:0] {
    DEST_QUERY = 2'd0,
    DEST_KEY   = 2'd1,
    DEST_VALUE = 2'd2
  } dest_t;

  // fp16 to fp32, subnormals normalized
  function automatic logic [31:0] half_to_single(input logic [15:0] h);
    logic       s;
    logic [4:0] e;
    logic [9:0] m;
    logic [3:0] p;
    logic [9:0] mn;
    logic [7:0] e32;
    s = h[15];
    e = h[14:10];
    m = h[9:0];
    p = 4'd0;
    for (int i = 0; i < 10; i++) begin
      if (m[i]) p = 4'(i);
    end
    mn  = 10'(m << (4'd10 - p));
    e32 = 8'd103 + {4'd0, p};
    if (e == 5'd31) begin
      return {s, 8'hFF, m, 13'd0};
    end else if (e == 5'd0) begin
      if (m == 10'd0) return {s, 31'd0};
      return {s, e32, mn, 13'd0};
    end
    return {s, 8'({3'd0, e} + 8'd112), m, 13'd0};
  endfunction

  // leading zero count, 48 when zero
  function automatic logic [5:0] lzc48(input logic [47:0] v);
    logic [5:0] n;
    n = 6'd48;
    for (int i = 0; i < 48; i++) begin
      if (v[i]) n = 6'(47 - i);
    end
    return n;
  endfunction

  // n has its leading one at bit 47, value n/2^47 * 2^(e-127); rne to fp32
  function automatic logic [31:0] round_fp32(input logic s, input logic signed [10:0] e,
                                             input logic [47:0] n);
    logic [5:0]  sh;
    logic [47:0] mask;
    logic [47:0] d;
    logic        stk;
    logic [7:0]  ef;
    logic [30:0] base;
    logic        up;
    if (e < 11'sd1) begin
      if (e < -11'sd47) sh = 6'd48;
      else sh = 6'(11'sd1 - e);
      ef = 8'd0;
    end else begin
      sh = 6'd0;
      ef = e[7:0];
    end
    mask = (48'd1 << sh) - 48'd1;
    d    = n >> sh;
    stk  = (|(n & mask)) | (|d[22:0]);
    base = {ef, d[46:24]};
    up   = d[23] & (stk | d[24]);
    if (n == 48'd0) return {s, 31'd0};
    if (e >= 11'sd255) return {s, 8'hFF, 23'd0};
    return {s, base + {30'd0, up}};
  endfunction

  // fp32 to bf16, rne, any nan canonical
  function automatic logic [15:0] single_to_bf16(input logic [31:0] b);
    logic [31:0] t;
    t = b + 32'h7FFF + {31'd0, b[16]};
    if (b[30:0] > 31'h7F800000) return BF16_QNAN;
    return t[31:16];
  endfunction

endpackage

[rtl/reh_fmul.sv]
// three stage fp32 multiplier, rne, subnormals kept
// uses reh_pkg
module reh_fmul (
  input  logic        clk,
  input  logic        en,
  input  logic [31:0] a,
  input  logic [31:0] b,
  output logic [31:0] y
);

  logic [7:0]  ea, eb;
  logic [23:0] ma, mb;
  logic        zero_a, zero_b, inf_a, inf_b, nan_a, nan_b;

  logic [47:0] p_r;
  logic [8:0]  es_r;
  logic        s1_r, nan1_r, inf1_r;

  logic [5:0]  lz;
  logic [47:0] n_r;
  logic signed [10:0] e_r;
  logic        s2_r, nan2_r, inf2_r;

  logic [31:0] y_r;

  always_comb begin
    ea     = (a[30:23] == 8'd0) ? 8'd1 : a[30:23];
    eb     = (b[30:23] == 8'd0) ? 8'd1 : b[30:23];
    ma     = {|a[30:23], a[22:0]};
    mb     = {|b[30:23], b[22:0]};
    zero_a = (a[30:0] == 31'd0);
    zero_b = (b[30:0] == 31'd0);
    inf_a  = (a[30:23] == 8'hFF) && (a[22:0] == 23'd0);
    inf_b  = (b[30:23] == 8'hFF) && (b[22:0] == 23'd0);
    nan_a  = (a[30:23] == 8'hFF) && (a[22:0] != 23'd0);
    nan_b  = (b[30:23] == 8'hFF) && (b[22:0] != 23'd0);
    lz     = reh_pkg::lzc48(p_r);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p_r    <= ma * mb;
      es_r   <= {1'b0, ea} + {1'b0, eb};
      s1_r   <= a[31] ^ b[31];
      nan1_r <= nan_a | nan_b | (inf_a & zero_b) | (inf_b & zero_a);
      inf1_r <= inf_a | inf_b;

      n_r    <= p_r << lz;
      e_r    <= $signed({2'd0, es_r}) - 11'sd126 - $signed({5'd0, lz});
      s2_r   <= s1_r;
      nan2_r <= nan1_r;
      inf2_r <= inf1_r;

      if (nan2_r) y_r <= reh_pkg::FP32_QNAN;
      else if (inf2_r) y_r <= {s2_r, 8'hFF, 23'd0};
      else y_r <= reh_pkg::round_fp32(s2_r, e_r, n_r);
    end
  end

  assign y = y_r;

endmodule

[rtl/reh_fadd.sv]
// three stage fp32 adder (align, add and normalize, round)
// uses reh_pkg
module reh_fadd (
  input  logic        clk,
  input  logic        en,
  input  logic [31:0] a,
  input  logic [31:0] b,
  output logic [31:0] y
);

  logic [31:0] x, w;
  logic [7:0]  ex, ew, d;
  logic [26:0] mx, mw, al, mask;
  logic        stk;
  logic        inf_a, inf_b, nan_a, nan_b;

  logic [7:0]  ex_r;
  logic [26:0] mx_r, al_r;
  logic        sx_r, sw_r, nan1_r, inf1_r, is1_r;

  logic [27:0] sum;
  logic [5:0]  lz;
  logic [47:0] n_r;
  logic signed [10:0] e_r;
  logic        s2_r, nan2_r, inf2_r, is2_r;

  logic [31:0] y_r;

  always_comb begin
    if (a[30:0] < b[30:0]) begin
      x = b;
      w = a;
    end else begin
      x = a;
      w = b;
    end
    ex = (x[30:23] == 8'd0) ? 8'd1 : x[30:23];
    ew = (w[30:23] == 8'd0) ? 8'd1 : w[30:23];
    mx = {|x[30:23], x[22:0], 3'd0};
    mw = {|w[30:23], w[22:0], 3'd0};
    d  = ex - ew;
    if (d > 8'd26) begin
      mask = 27'd0;
      al   = 27'd0;
      stk  = |mw;
    end else begin
      mask = (27'd1 << d[4:0]) - 27'd1;
      al   = mw >> d[4:0];
      stk  = |(mw & mask);
    end
    inf_a = (a[30:23] == 8'hFF) && (a[22:0] == 23'd0);
    inf_b = (b[30:23] == 8'hFF) && (b[22:0] == 23'd0);
    nan_a = (a[30:23] == 8'hFF) && (a[22:0] != 23'd0);
    nan_b = (b[30:23] == 8'hFF) && (b[22:0] != 23'd0);

    // magnitude of x is never below the aligned w
    if (sx_r ^ sw_r) sum = {1'b0, mx_r} - {1'b0, al_r};
    else sum = {1'b0, mx_r} + {1'b0, al_r};
    lz = reh_pkg::lzc48({sum, 20'd0});
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ex_r   <= ex;
      mx_r   <= mx;
      al_r   <= {al[26:1], al[0] | stk};
      sx_r   <= x[31];
      sw_r   <= w[31];
      nan1_r <= nan_a | nan_b | (inf_a & inf_b & (a[31] ^ b[31]));
      inf1_r <= inf_a | inf_b;
      is1_r  <= inf_a ? a[31] : b[31];

      n_r    <= {sum, 20'd0} << lz;
      e_r    <= $signed({3'd0, ex_r}) + 11'sd1 - $signed({5'd0, lz});
      // exact cancellation gives +0 unless both inputs are negative
      s2_r   <= (sum == 28'd0) ? (sx_r & sw_r) : sx_r;
      nan2_r <= nan1_r;
      inf2_r <= inf1_r;
      is2_r  <= is1_r;

      if (nan2_r) y_r <= reh_pkg::FP32_QNAN;
      else if (inf2_r) y_r <= {is2_r, 8'hFF, 23'd0};
      else y_r <= reh_pkg::round_fp32(s2_r, e_r, n_r);
    end
  end

  assign y = y_r;

endmodule

[rtl/rotary_embedding_head_router.sv]
// top level of the rotary embedding head router: input stage, fp32 datapath, routing
// uses reh_pkg, reh_fmul and reh_fadd
//
// Takes one element pair (i, i+128) of a head per word and returns one word per
// input; the pipeline has eight register stages, the last being the output register,
// and a new word can enter every cycle while the output word is not stalled.
// Query heads and the key head are rotated with separately rounded fp32 multiplies
// (three stages) and adds (three stages); the value head passes through. Results
// are bf16, any nan comes out as 0x7FC0. The whole pipeline advances together and
// freezes while the output word is stalled, so in_stall follows out_stall only
// when the output register is full. position_offset is written at byte address 0.
module rotary_embedding_head_router (
  input  logic        clk,
  input  logic        rst_n,

  input  logic        in_valid,
  output logic        in_stall,
  input  logic [11:0] in_row_index,
  input  logic [3:0]  in_head_index,
  input  logic [6:0]  in_pair_index,
  input  logic [15:0] in_x_first,
  input  logic [15:0] in_x_second,
  input  logic [31:0] in_cos_first,
  input  logic [31:0] in_cos_second,
  input  logic [31:0] in_sin_first,
  input  logic [31:0] in_sin_second,

  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_dest_select,
  output logic [15:0] out_dest_row,
  output logic [10:0] out_dest_col,
  output logic [15:0] out_y_first,
  output logic [15:0] out_y_second,

  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  localparam int SB_STAGES = reh_pkg::PIPE_DEPTH - 1;

  // routing info and pass-through operands that ride along with the math
  typedef struct packed {
    logic [1:0]  dest;
    logic [15:0] row;
    logic [10:0] col;
    logic        pass;
    logic [31:0] a1;
    logic [31:0] a2;
  } sb_t;

  logic [15:0] pos_offset_r;

  logic        en;
  logic        valid_r [reh_pkg::PIPE_DEPTH];
  sb_t         sb_r    [SB_STAGES];
  sb_t         sb_nxt;

  // operands held in the input stage
  logic [31:0] c1_r, c2_r, s1_r, s2_r;

  logic [31:0] p1, q1, p2, q2, f1, f2;

  logic [1:0]  out_dest_r;
  logic [15:0] out_row_r, out_y1_r, out_y2_r;
  logic [10:0] out_col_r;

  // config port, register index 0 only
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_offset_r <= 16'd0;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready && !cfg_paddr[2]) begin
      pos_offset_r <= cfg_pwdata[15:0];
    end
  end

  assign cfg_pready = 1'b1;
  assign cfg_prdata = cfg_paddr[2] ? 32'd0 : {16'd0, pos_offset_r};

  // global advance: everything moves unless the output word is held
  assign en       = !valid_r[reh_pkg::PIPE_DEPTH-1] || !out_stall;
  assign in_stall = !en;

  // destination decode and address math for the incoming word
  always_comb begin
    sb_nxt.a1   = reh_pkg::half_to_single(in_x_first);
    sb_nxt.a2   = reh_pkg::half_to_single(in_x_second);
    sb_nxt.pass = (in_head_index > 4'(reh_pkg::QUERY_HEADS));
    if (in_head_index < 4'(reh_pkg::QUERY_HEADS)) begin
      sb_nxt.dest = reh_pkg::DEST_QUERY;
      sb_nxt.row  = {4'd0, in_row_index};
      sb_nxt.col  = 11'(32'(in_head_index) * reh_pkg::HEAD_DIM + 32'(in_pair_index));
    end else begin
      sb_nxt.dest = (in_head_index == 4'(reh_pkg::QUERY_HEADS)) ? reh_pkg::DEST_KEY
                                                                : reh_pkg::DEST_VALUE;
      // key and value rows wrap at 16 bits
      sb_nxt.row  = pos_offset_r + {4'd0, in_row_index};
      sb_nxt.col  = {4'd0, in_pair_index};
    end
  end

  // valid bits travel with the data
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < reh_pkg::PIPE_DEPTH; i++) valid_r[i] <= 1'b0;
    end else if (en) begin
      valid_r[0] <= in_valid;
      for (int i = 1; i < reh_pkg::PIPE_DEPTH; i++) valid_r[i] <= valid_r[i-1];
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk) begin
    if (en) begin
      sb_r[0] <= sb_nxt;
      for (int i = 1; i < SB_STAGES; i++) sb_r[i] <= sb_r[i-1];
      c1_r <= in_cos_first;
      c2_r <= in_cos_second;
      s1_r <= in_sin_first;
      s2_r <= in_sin_second;
    end
  end

  // four products, each rounded on its own
  reh_fmul u_mul_p1 (.clk(clk), .en(en), .a(sb_r[0].a1), .b(c1_r), .y(p1));
  reh_fmul u_mul_q1 (.clk(clk), .en(en), .a(sb_r[0].a2), .b(s1_r), .y(q1));
  reh_fmul u_mul_p2 (.clk(clk), .en(en), .a(sb_r[0].a2), .b(c2_r), .y(p2));
  reh_fmul u_mul_q2 (.clk(clk), .en(en), .a(sb_r[0].a1), .b(s2_r), .y(q2));

  // first = p1 - q1 by flipping the sign of q1, second = p2 + q2
  reh_fadd u_add_first  (.clk(clk), .en(en), .a(p1), .b({~q1[31], q1[30:0]}), .y(f1));
  reh_fadd u_add_second (.clk(clk), .en(en), .a(p2), .b(q2), .y(f2));

  // output stage: pass-through select and bf16 rounding
  always_ff @(posedge clk) begin
    if (en) begin
      out_dest_r <= sb_r[SB_STAGES-1].dest;
      out_row_r  <= sb_r[SB_STAGES-1].row;
      out_col_r  <= sb_r[SB_STAGES-1].col;
      out_y1_r   <= reh_pkg::single_to_bf16(sb_r[SB_STAGES-1].pass ? sb_r[SB_STAGES-1].a1 : f1);
      out_y2_r   <= reh_pkg::single_to_bf16(sb_r[SB_STAGES-1].pass ? sb_r[SB_STAGES-1].a2 : f2);
    end
  end

  assign out_valid       = valid_r[reh_pkg::PIPE_DEPTH-1];
  assign out_dest_select = out_dest_r;
  assign out_dest_row    = out_row_r;
  assign out_dest_col    = out_col_r;
  assign out_y_first     = out_y1_r;
  assign out_y_second    = out_y2_r;

endmodule

[rtl/reh_checker.sv]
// port level checks for the rotary embedding head router, bound to the top level
// uses only the top level's ports
module reh_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [1:0]  out_dest_select,
  input logic [15:0] out_dest_row,
  input logic [10:0] out_dest_col,
  input logic [15:0] out_y_first,
  input logic [15:0] out_y_second
);

  // input is held back only by a full, stalled output register
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (out_valid && out_stall))
    else $error("input stalled without a stalled output word");

  // key and value columns are the pair index alone
  a_kv_col: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_dest_select != 2'd0) |-> (out_dest_col[10:7] == 4'd0))
    else $error("key or value column out of range");

  // any nan result on y_first is canonical
  a_nan_canon: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_y_first[14:7] == 8'hFF && out_y_first[6:0] != 7'd0)
      |-> (out_y_first == 16'h7FC0))
    else $error("non canonical nan on y_first");

  // a stalled output word holds its y values and row
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_y_first) &&
      $stable(out_y_second) && $stable(out_dest_row)))
    else $error("stalled output word changed");

endmodule

bind rotary_embedding_head_router reh_checker u_reh_checker (.*);
